// File: hw/rtl/lmef_pkg.sv
// ----------------------------------------------------------------------------
// lmef_pkg
// Shared constants and types of the lookahead minimum envelope follower.
// ----------------------------------------------------------------------------
package lmef_pkg;

  localparam int MaxLookahead = 32;
  localparam int Depth        = MaxLookahead + 1;
  localparam int IdxW         = $clog2(Depth);
  localparam int FovW         = 16;
  localparam int CoeffW       = 16;
  localparam int LevelW       = 32;
  localparam int QueueW       = IdxW + FovW;

  localparam logic [FovW-1:0]   FullScale     = 16'd32768;
  localparam logic [CoeffW-1:0] FastCoeffRst  = 16'd10059;
  localparam logic [CoeffW-1:0] SlowCoeffRst  = 16'd545;
  localparam logic [IdxW-1:0]   LookaheadRst  = '0;

  typedef enum logic [1:0] {
    CfgFastCoeff = 2'd0,
    CfgSlowCoeff = 2'd1,
    CfgLookahead = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic            load;
    logic [FovW-1:0] load_val;
    logic            step;
    logic [FovW-1:0] target;
  } filt_req_t;

  typedef struct packed {
    logic            valid;
    logic [FovW-1:0] fov;
    logic            last;
  } emit_t;

  typedef struct packed {
    logic [IdxW-1:0] cnt;
    logic [IdxW-1:0] pend;
  } seq_stat_t;

endpackage

// File: hw/rtl/lookahead_min_envelope_follower_top.sv
// ----------------------------------------------------------------------------
// lookahead_min_envelope_follower_top
// Lookahead window minimum feeding an attack/release envelope follower.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per frame: tdata = required FOV (Q1.15,
//   values above 1.0 saturate), tlast marks the final frame of a clip.
//   m_axis returns one smoothed FOV per frame, tlast on the clip's final frame.
//   cfg writes fast_coeff (0), slow_coeff (1) and lookahead_frames (2); write
//   only while idle. Lookahead is latched at the first frame of each clip.
//   Results lag inputs by the lookahead; the tlast request flushes all pending
//   frames, one result each.
// Flow:
//   One request at a time; s_axis_tready is high only while idle. Intake runs
//   the expire and push loops; each result runs the expire loop, then the
//   read, target, filter and output steps, and waits out any m_axis stall.
//   A flush adds one result step per pending frame.
// Reset clears clip state and loads default coefficients. A stalled m_axis
//   holds the output register; the sequencer waits for it to free.
// ----------------------------------------------------------------------------
module lookahead_min_envelope_follower_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] fov_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] fov_out
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import lmef_pkg::*;

  logic [CoeffW-1:0] fast_q, slow_q;
  logic [IdxW-1:0]   look_q;
  logic              out_vld_q;
  logic [FovW-1:0]   out_fov_q;
  logic              out_last_q;
  logic              out_free;

  filt_req_t         filt_req;
  emit_t             emit;
  seq_stat_t         stat;
  logic [FovW-1:0]   lvl;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q <= FastCoeffRst;
      slow_q <= SlowCoeffRst;
      look_q <= LookaheadRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgFastCoeff: fast_q <= cfg_data_i;
        CfgSlowCoeff: slow_q <= cfg_data_i;
        CfgLookahead: look_q <= cfg_data_i[IdxW-1:0];
        default: ;
      endcase
    end
  end

  lmef_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_fov_i    (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .lookahead_i (look_q),
    .out_free_i  (out_free),
    .filt_o      (filt_req),
    .lvl_i       (lvl),
    .emit_o      (emit),
    .stat_o      (stat)
  );

  lmef_filter u_filter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fast_i (fast_q),
    .slow_i (slow_q),
    .req_i  (filt_req),
    .lvl_o  (lvl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit.valid) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_fov_q  <= emit.fov;
      out_last_q <= emit.last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_fov_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while sequencer busy");

  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.valid |-> out_free)
    else $error("result written over an untaken result");

  a_counts_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.cnt <= IdxW'(Depth)) && (stat.pend <= IdxW'(Depth)))
    else $error("queue or pending count out of range");
`endif

endmodule

// File: hw/rtl/lmef_ram.sv
// ----------------------------------------------------------------------------
// lmef_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmef_ram #(
  parameter int Width = 16,
  parameter int Depth = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lmef_filter.sv
// ----------------------------------------------------------------------------
// lmef_filter
// One-pole envelope level with separate tighten and open coefficients.
// Multiply into a register on a step, update the level in the next.
// ----------------------------------------------------------------------------
module lmef_filter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lmef_pkg::CoeffW-1:0] fast_i,
  input  logic [lmef_pkg::CoeffW-1:0] slow_i,
  input  lmef_pkg::filt_req_t         req_i,
  output logic [lmef_pkg::FovW-1:0]   lvl_o
);
  import lmef_pkg::*;

  localparam int MagW = LevelW + CoeffW;

  logic [LevelW-1:0] level_q;
  logic [MagW-1:0]   mag_q;
  logic              down_q;
  logic              upd_q;

  logic [LevelW-1:0] tgt;
  logic              down;
  logic [LevelW-1:0] diff;
  logic [CoeffW-1:0] coeff;
  logic [MagW:0]     rnd_sum;
  logic [LevelW-1:0] amt;
  logic [LevelW:0]   lvl_sum;
  logic [FovW:0]     lvl_rnd;

  assign tgt     = {req_i.target, 16'd0};
  assign down    = tgt < level_q;
  assign diff    = down ? (level_q - tgt) : (tgt - level_q);
  assign coeff   = down ? fast_i : slow_i;
  assign rnd_sum = {1'b0, mag_q} + (MagW+1)'(32768);
  assign amt     = rnd_sum[LevelW+15:16];

  assign lvl_sum = {1'b0, level_q} + (LevelW+1)'(32768);
  assign lvl_rnd = lvl_sum[LevelW:16];
  assign lvl_o   = (lvl_rnd > {1'b0, FullScale}) ? FullScale : lvl_rnd[FovW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      upd_q   <= 1'b0;
      down_q  <= 1'b0;
    end else begin
      upd_q <= req_i.step;
      if (req_i.step) begin
        down_q <= down;
      end
      if (req_i.load) begin
        level_q <= {req_i.load_val, 16'd0};
      end else if (upd_q) begin
        level_q <= down_q ? (level_q - amt) : (level_q + amt);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.step) begin
      mag_q <= diff * coeff;
    end
  end

endmodule

// File: hw/rtl/lmef_seq.sv
// ----------------------------------------------------------------------------
// lmef_seq
// Sequencer around the min-queue and sample delay RAMs: expire, push,
// and per-frame result steps.
// ----------------------------------------------------------------------------
module lmef_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [lmef_pkg::FovW-1:0] in_fov_i,
  input  logic                      in_last_i,
  input  logic [lmef_pkg::IdxW-1:0] lookahead_i,
  input  logic                      out_free_i,
  output lmef_pkg::filt_req_t       filt_o,
  input  logic [lmef_pkg::FovW-1:0] lvl_i,
  output lmef_pkg::emit_t           emit_o,
  output lmef_pkg::seq_stat_t       stat_o
);
  import lmef_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXP_RD,
    S_EXP_CHK,
    S_PSH_RD,
    S_PSH_CHK,
    S_PSH_WR,
    S_DECIDE,
    S_EM_RD,
    S_EM_TGT,
    S_EM_FLT,
    S_EM_OUT
  } state_e;

  function automatic logic [IdxW-1:0] ptr_inc(input logic [IdxW-1:0] p);
    return (p == IdxW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] ptr_dec(input logic [IdxW-1:0] p);
    return (p == '0) ? IdxW'(Depth - 1) : p - 1'b1;
  endfunction

  state_e          state_q;
  logic [IdxW-1:0] head_q, tail_q, cnt_q, fpos_q, pend_q, wp_q, win_q;
  logic            first_q, last_q, emit_q;
  logic [FovW-1:0] v_q;

  logic [FovW-1:0]   in_clamp;
  logic [IdxW-1:0]   win_sat;
  logic [IdxW-1:0]   pos, diff, back, rd_ptr;
  logic [IdxW:0]     rd_sum;
  logic              accept;

  logic              q_we;
  logic [QueueW-1:0] q_wdata, q_rdata;
  logic [IdxW-1:0]   q_raddr;
  logic [FovW-1:0]   d_rdata;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_clamp   = (in_fov_i > FullScale) ? FullScale : in_fov_i;
  assign win_sat    = (lookahead_i > IdxW'(MaxLookahead)) ? IdxW'(MaxLookahead) : lookahead_i;

  assign pos    = fpos_q - pend_q;
  assign diff   = pos - q_rdata[QueueW-1:FovW];
  assign back   = ptr_dec(tail_q);
  assign rd_sum = (wp_q >= pend_q) ? ({1'b0, wp_q} - {1'b0, pend_q})
                                   : ({1'b0, wp_q} + (IdxW+1)'(Depth) - {1'b0, pend_q});
  assign rd_ptr = rd_sum[IdxW-1:0];

  assign q_we    = (state_q == S_PSH_WR);
  assign q_wdata = {fpos_q, v_q};
  assign q_raddr = (state_q == S_PSH_RD) ? back : head_q;

  lmef_ram #(.Width(QueueW), .Depth(Depth)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (tail_q),
    .wdata_i (q_wdata),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  lmef_ram #(.Width(FovW), .Depth(Depth)) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (wp_q),
    .wdata_i (v_q),
    .raddr_i (rd_ptr),
    .rdata_o (d_rdata)
  );

  always_comb begin
    filt_o.load     = accept && first_q;
    filt_o.load_val = in_clamp;
    filt_o.step     = (state_q == S_EM_TGT);
    filt_o.target   = (cnt_q != '0) ? q_rdata[FovW-1:0] : '0;
    emit_o.valid    = (state_q == S_EM_OUT) && out_free_i;
    emit_o.fov      = (lvl_i < d_rdata) ? lvl_i : d_rdata;
    emit_o.last     = last_q && (pend_q == IdxW'(1));
    stat_o.cnt      = cnt_q;
    stat_o.pend     = pend_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      fpos_q  <= '0;
      pend_q  <= '0;
      wp_q    <= '0;
      win_q   <= '0;
      first_q <= 1'b1;
      last_q  <= 1'b0;
      emit_q  <= 1'b0;
      v_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            v_q    <= in_clamp;
            last_q <= in_last_i;
            emit_q <= 1'b0;
            if (first_q) begin
              win_q   <= win_sat;
              first_q <= 1'b0;
            end
            state_q <= S_EXP_RD;
          end
        end
        S_EXP_RD: begin
          if (cnt_q == '0) begin
            state_q <= emit_q ? S_EM_RD : S_PSH_RD;
          end else begin
            state_q <= S_EXP_CHK;
          end
        end
        S_EXP_CHK: begin
          // head is older than the current window start
          if (diff != '0 && !diff[IdxW-1]) begin
            head_q  <= ptr_inc(head_q);
            cnt_q   <= cnt_q - 1'b1;
            state_q <= S_EXP_RD;
          end else begin
            state_q <= emit_q ? S_EM_RD : S_PSH_RD;
          end
        end
        S_PSH_RD: begin
          state_q <= (cnt_q == '0) ? S_PSH_WR : S_PSH_CHK;
        end
        S_PSH_CHK: begin
          if (q_rdata[FovW-1:0] < v_q) begin
            state_q <= S_PSH_WR;
          end else begin
            tail_q  <= back;
            cnt_q   <= cnt_q - 1'b1;
            state_q <= S_PSH_RD;
          end
        end
        S_PSH_WR: begin
          if (cnt_q == IdxW'(Depth)) begin
            head_q <= ptr_inc(head_q);
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
          tail_q  <= ptr_inc(tail_q);
          wp_q    <= ptr_inc(wp_q);
          fpos_q  <= fpos_q + 1'b1;
          pend_q  <= pend_q + 1'b1;
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (last_q) begin
            if (pend_q != '0) begin
              emit_q  <= 1'b1;
              state_q <= S_EXP_RD;
            end else begin
              head_q  <= '0;
              tail_q  <= '0;
              cnt_q   <= '0;
              fpos_q  <= '0;
              wp_q    <= '0;
              win_q   <= '0;
              first_q <= 1'b1;
              last_q  <= 1'b0;
              state_q <= S_IDLE;
            end
          end else if (pend_q > win_q) begin
            emit_q  <= 1'b1;
            state_q <= S_EXP_RD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_EM_RD: begin
          state_q <= S_EM_TGT;
        end
        S_EM_TGT: begin
          state_q <= S_EM_FLT;
        end
        S_EM_FLT: begin
          state_q <= S_EM_OUT;
        end
        S_EM_OUT: begin
          if (out_free_i) begin
            pend_q  <= pend_q - 1'b1;
            state_q <= S_DECIDE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: test/tb_lookahead_min_envelope_follower_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lookahead_min_envelope_follower_top
// Self-checking bench for the lookahead minimum envelope follower.
// Clips of required-FOV frames go in on s_axis and smoothed FOV comes back on
// m_axis. A scoreboard runs its own window-minimum and attack/release filter
// per accepted frame and checks every result in order. The bench covers
// directed extremes, saturation of the input and the lookahead, zero
// coefficients, lookahead writes inside a clip and one-frame clips, and then
// random clips under random register settings with random stalls, one long
// output hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb_lookahead_min_envelope_follower_top;
  import lmef_pkg::*;

  localparam logic [1:0] CfgSpare     = 2'd3;
  localparam int         DrainCycles  = 200;
  localparam int         HoldOffCycles = 600;
  localparam int         TargetFrames = 300;
  localparam longint     TimeoutNs    = 18_000_000;

  typedef struct {
    logic [15:0] fov;
    logic        last;
  } fov_result_t;

  typedef struct {
    logic [1:0]  idx;
    logic [15:0] data;
  } reg_write_t;

  class envelope_scoreboard;
    logic [15:0] fast_c, slow_c;
    logic [5:0]  look_c;
    logic [31:0] level;
    logic [15:0] delay_line [Depth];
    logic [15:0] q_val [Depth];
    logic [15:0] q_pos [Depth];
    int          q_head, q_tail, q_count;
    logic [15:0] frame_pos;
    bit          awaiting_first;
    int          pend, wptr, active_w;
    fov_result_t fov_expected_q [$];
    int          errors;
    int          checked;

    function new();
      fast_c  = FastCoeffRst;
      slow_c  = SlowCoeffRst;
      look_c  = LookaheadRst;
      level   = '0;
      errors  = 0;
      checked = 0;
      clear_clip();
    endfunction

    function void clear_clip();
      foreach (delay_line[i]) begin
        delay_line[i] = '0;
        q_val[i]      = '0;
        q_pos[i]      = '0;
      end
      q_head         = 0;
      q_tail         = 0;
      q_count        = 0;
      frame_pos      = '0;
      awaiting_first = 1'b1;
      pend           = 0;
      wptr           = 0;
      active_w       = 0;
    endfunction

    function void note_config(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CfgFastCoeff: fast_c = data;
        CfgSlowCoeff: slow_c = data;
        CfgLookahead: look_c = data[5:0];
        default: ;
      endcase
    endfunction

    // drop window entries older than pos
    function void expire(logic [15:0] pos);
      logic [15:0] diff;
      while (q_count > 0) begin
        diff = pos - q_pos[q_head];
        if (diff == 16'd0 || diff >= 16'h8000) break;
        q_head = (q_head + 1) % Depth;
        q_count--;
      end
    endfunction

    function void push_min(logic [15:0] v, logic [15:0] pos);
      int back;
      while (q_count > 0) begin
        back = (q_tail + Depth - 1) % Depth;
        if (q_val[back] < v) break;
        q_tail = back;
        q_count--;
      end
      if (q_count >= Depth) begin
        q_head = (q_head + 1) % Depth;
        q_count--;
      end
      q_val[q_tail] = v;
      q_pos[q_tail] = pos;
      q_tail = (q_tail + 1) % Depth;
      q_count++;
    endfunction

    function void follow(logic [15:0] tgt);
      logic [31:0] t;
      logic [63:0] span, mag;
      t = {tgt, 16'h0000};
      if (t < level) begin
        span = {32'd0, level - t};
        mag = (span * {48'd0, fast_c} + 64'd32768) >> 16;
        level = level - mag[31:0];
      end else begin
        span = {32'd0, t - level};
        mag = (span * {48'd0, slow_c} + 64'd32768) >> 16;
        level = level + mag[31:0];
      end
    endfunction

    function void emit_frame(bit is_last);
      logic [15:0] pos, tgt, smp;
      logic [31:0] rnd;
      fov_result_t r;
      pos = frame_pos - 16'(pend);
      expire(pos);
      tgt = (q_count > 0) ? q_val[q_head] : 16'd0;
      follow(tgt);
      smp = delay_line[(wptr + Depth - pend) % Depth];
      rnd = (level + 32'h0000_8000) >> 16;
      if (rnd > 32'(FullScale)) rnd = 32'(FullScale);
      r.fov  = (rnd[15:0] < smp) ? rnd[15:0] : smp;
      r.last = is_last;
      fov_expected_q.insert(fov_expected_q.size(), r);
      pend--;
    endfunction

    function void note_input(logic [15:0] fov, logic last);
      logic [15:0] v;
      v = (fov > FullScale) ? FullScale : fov;
      if (awaiting_first) begin
        active_w       = (look_c > MaxLookahead) ? MaxLookahead : int'(look_c);
        level          = {v, 16'h0000};
        awaiting_first = 1'b0;
      end
      expire(frame_pos - 16'(pend));
      push_min(v, frame_pos);
      delay_line[wptr] = v;
      wptr      = (wptr + 1) % Depth;
      frame_pos = frame_pos + 16'd1;
      pend++;
      if (last) begin
        while (pend > 0) emit_frame(pend == 1);
        clear_clip();
      end else if (pend > active_w) begin
        emit_frame(1'b0);
      end
    endfunction

    function void check_result(logic [15:0] fov, logic last);
      fov_result_t e;
      checked++;
      if (fov_expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: fov %0d last %0b", fov, last);
        return;
      end
      e = fov_expected_q[0];
      fov_expected_q.delete(0);
      if (fov !== e.fov || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("result %0d mismatch: fov expected %0d got %0d, last expected %0b got %0b",
                   checked, e.fov, fov, e.last, last);
      end
    endfunction

    function int pending_results();
      return fov_expected_q.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;

  envelope_scoreboard sb = new();
  reg_write_t         reg_writes [$];
  int                 frames_sent = 0;
  int                 cur_look    = 0;
  logic [15:0]        prev_fov    = '0;
  bit                 steady      = 1'b0;

  lookahead_min_envelope_follower_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic send_frame(input logic [15:0] fov, input logic last);
    int gap;
    gap = 0;
    steady = (frames_sent >= 180 && frames_sent < 240);
    if (!steady && $urandom_range(99) < 30)
      gap = ($urandom_range(9) == 0) ? $urandom_range(4, 60) : $urandom_range(1, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= fov;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(fov, last);
    frames_sent++;
  endtask

  // sender idles until every expected result is back, then lets the block settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic void queue_write(logic [1:0] idx, logic [15:0] data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    reg_writes.insert(reg_writes.size(), w);
  endfunction

  task automatic apply_reg_writes();
    reg_write_t w;
    while (reg_writes.size() != 0) begin
      w = reg_writes[0];
      reg_writes.delete(0);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= w.idx;
      cfg_data_i  <= w.data;
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.note_config(w.idx, w.data);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_coeff();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic pick_regs(input int clip_no);
    logic [15:0] fast, slow;
    logic [5:0]  la;
    fast = pick_coeff();
    slow = pick_coeff();
    case ($urandom_range(9))
      0, 1: la = 6'd0;
      2, 3: la = 6'd32;
      4: la = 6'($urandom_range(33, 63));
      default: la = 6'($urandom_range(1, 8));
    endcase
    if (clip_no == 1) begin
      fast = 16'd1;
      slow = 16'd1;
      la   = 6'd32;
    end
    if (clip_no == 5) la = 6'd63;
    queue_write(CfgLookahead, {10'($urandom), la});
    queue_write(CfgFastCoeff, fast);
    queue_write(CfgSlowCoeff, slow);
    if ($urandom_range(3) == 0) queue_write(CfgSpare, 16'($urandom));
    cur_look = (la > MaxLookahead) ? MaxLookahead : int'(la);
    apply_reg_writes();
  endtask

  function automatic logic [15:0] next_fov(input logic [15:0] prev);
    int v;
    case ($urandom_range(9))
      0: return 16'd0;
      1: return FullScale;
      2, 3: return 16'($urandom);
      4: return 16'($urandom_range(1, 200));
      default: begin
        v = int'(prev) + int'($urandom_range(0, 6000)) - 3000;
        if (v < 0) v = 0;
        if (v > int'(FullScale)) v = int'(FullScale);
        return 16'(v);
      end
    endcase
  endfunction

  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
      if (!held && sb.checked >= 40) begin
        held = 1'b1;
        hold = HoldOffCycles;
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 30);
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("status: fail");
    $finish;
  end

  initial begin
    int clip_no, len;
    logic [15:0] v;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default registers, no lookahead; zero, full scale, saturation
    send_frame(16'd0, 1'b0);
    send_frame(FullScale, 1'b0);
    send_frame(16'hFFFF, 1'b0);
    send_frame(16'd32767, 1'b0);
    send_frame(16'd12345, 1'b1);
    wait_drained();

    // fastest tighten, frozen open, lookahead 3, write to an unused index
    queue_write(CfgFastCoeff, 16'hFFFF);
    queue_write(CfgSlowCoeff, 16'd0);
    queue_write(CfgLookahead, 16'd3);
    queue_write(CfgSpare, 16'hFFFF);
    apply_reg_writes();
    send_frame(16'd20000, 1'b0);
    send_frame(16'd8000, 1'b0);
    // lookahead change inside a clip applies to the next clip only
    wait_drained();
    queue_write(CfgLookahead, 16'hFFC1);
    apply_reg_writes();
    send_frame(16'd30000, 1'b0);
    send_frame(16'h8001, 1'b0);
    send_frame(16'd100, 1'b1);
    send_frame(16'hAAAA, 1'b1);
    wait_drained();

    // frozen tighten, fastest open, lookahead above the maximum
    queue_write(CfgFastCoeff, 16'd0);
    queue_write(CfgSlowCoeff, 16'hFFFF);
    queue_write(CfgLookahead, 16'd63);
    apply_reg_writes();
    cur_look = MaxLookahead;
    for (int i = 0; i < 10; i++)
      send_frame(i[0] ? 16'h5555 : 16'h2AAA, i == 9);

    clip_no = 0;
    while (frames_sent < TargetFrames) begin
      if (clip_no == 1 || clip_no == 5 || $urandom_range(9) < 6) begin
        wait_drained();
        pick_regs(clip_no);
      end
      if (clip_no == 1) len = 45;
      else if (clip_no == 5) len = 36;
      else if ($urandom_range(3) == 0) len = $urandom_range(1, 3);
      else len = $urandom_range(1, cur_look + 12);
      for (int i = 0; i < len; i++) begin
        if (clip_no == 4 && i == len / 2) wait_drained();
        v = (clip_no == 1) ? 16'(i * 700) : next_fov(prev_fov);
        prev_fov = v;
        send_frame(v, i == len - 1);
      end
      clip_no++;
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending_results() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
